// ===== rtl/simon_pkg.sv =====
// Simon 32/64 constants, round function and key schedule step.
package simon_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned BLOCK_W     = 32;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned RIDX_W      = $clog2(ROUND_COUNT);

  localparam logic [WORD_W-1:0] KEY_CONST = 16'hFFFC;
  localparam logic [63:0]       Z0_SEQ    = 64'h19C3522FB386A45F;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // f(x) = (x <<< 1 & x <<< 8) ^ x <<< 2
  function automatic word_t round_f(input word_t x);
    word_t r1, r2, r8;
    r1 = {x[14:0], x[15]};
    r2 = {x[13:0], x[15:14]};
    r8 = {x[7:0], x[15:8]};
    return (r1 & r8) ^ r2;
  endfunction

  // Next key word from k0, k1, k3 and one bit of z0.
  function automatic word_t key_step(input word_t k0, input word_t k1,
                                     input word_t k3, input logic zbit);
    word_t t;
    t = {k3[2:0], k3[15:3]} ^ k1;
    return t ^ {t[0], t[15:1]} ^ k0 ^ KEY_CONST ^ {15'd0, zbit};
  endfunction

endpackage

// ===== rtl/simon32_64_cipher.sv =====
// Simon 32/64 block cipher: key expansion and 32-stage round pipeline.
// An accepted block passes through every round stage before done_o; one Feistel round per stage.
// Throughput: one block per cycle while busy is low; the unrolled round pipeline never stalls.
// Key load: a key write re-expands the round keys while busy is high.
// Reset: round keys are expanded from the all-zero key while busy is high.
// The receiver cannot stall: done_o marks block_out_o for exactly one cycle.
module simon32_64_cipher
  import simon_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               operation_i,
  input  logic [BLOCK_W-1:0] block_in_i,
  output logic               done_o,
  output logic [BLOCK_W-1:0] block_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [KEY_W-1:0]   cipher_key_i
);

  // ---------------------------------------------------------------------------
  // Key schedule: while busy is high, four key words slide one step per cycle
  // and one round key is written per cycle into the round key registers.
  // ---------------------------------------------------------------------------
  word_t             kw_q [4];
  word_t             rk_q [ROUND_COUNT];
  logic [RIDX_W-1:0] exp_cnt_q;
  logic              exp_busy_q;
  logic              cfg_wr;
  word_t             kw_next;

  localparam logic [RIDX_W-1:0] LastStep = RIDX_W'(ROUND_COUNT - 2);

  // Take a key at any time; a write restarts the expansion.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy        = exp_busy_q;

  assign kw_next = key_step(kw_q[0], kw_q[1], kw_q[3], Z0_SEQ[{1'b0, exp_cnt_q}]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_busy_q <= 1'b1;
      exp_cnt_q  <= '0;
      for (int i = 0; i < 4; i++) kw_q[i] <= '0;
      for (int i = 0; i < ROUND_COUNT; i++) rk_q[i] <= '0;
    end else if (cfg_wr) begin
      // Load the new key and restart the expansion at round key 1.
      exp_busy_q <= 1'b1;
      exp_cnt_q  <= '0;
      for (int i = 0; i < 4; i++) kw_q[i] <= cipher_key_i[WORD_W*i +: WORD_W];
      rk_q[0] <= cipher_key_i[WORD_W-1:0];
    end else if (exp_busy_q) begin
      // Advance the key words; old k1 becomes the next round key.
      rk_q[exp_cnt_q + 1'b1] <= kw_q[1];
      kw_q[0] <= kw_q[1];
      kw_q[1] <= kw_q[2];
      kw_q[2] <= kw_q[3];
      kw_q[3] <= kw_next;
      exp_cnt_q <= exp_cnt_q + 1'b1;
      if (exp_cnt_q == LastStep) begin
        exp_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round pipeline: stage r holds the halves after round r. Decryption
  // enters with swapped halves and reads the round keys in reverse order.
  // ---------------------------------------------------------------------------
  logic  accept;
  logic  vld_q [ROUND_COUNT];
  logic  op_q  [ROUND_COUNT];
  word_t a_q   [ROUND_COUNT];
  word_t b_q   [ROUND_COUNT];

  assign accept = start && !busy;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    logic  vld_in;
    logic  op_in;
    word_t a_in;
    word_t b_in;
    word_t key;

    if (r == 0) begin : g_first
      assign vld_in = accept;
      assign op_in  = operation_i;
      assign a_in   = (operation_i == OP_DECRYPT) ? block_in_i[WORD_W-1:0]
                                                  : block_in_i[BLOCK_W-1:WORD_W];
      assign b_in   = (operation_i == OP_DECRYPT) ? block_in_i[BLOCK_W-1:WORD_W]
                                                  : block_in_i[WORD_W-1:0];
    end else begin : g_next
      assign vld_in = vld_q[r-1];
      assign op_in  = op_q[r-1];
      assign a_in   = a_q[r-1];
      assign b_in   = b_q[r-1];
    end

    assign key = (op_in == OP_DECRYPT) ? rk_q[ROUND_COUNT-1-r] : rk_q[r];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r] <= 1'b0;
      end else begin
        vld_q[r] <= vld_in;
      end
    end

    // Data needs no reset; hold it when the stage has nothing to carry.
    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        op_q[r] <= op_in;
        a_q[r]  <= round_f(a_in) ^ b_in ^ key;
        b_q[r]  <= a_in;
      end
    end
  end

  // Undo the decrypt swap on the way out.
  assign done_o      = vld_q[ROUND_COUNT-1];
  assign block_out_o = (op_q[ROUND_COUNT-1] == OP_DECRYPT)
                     ? {b_q[ROUND_COUNT-1], a_q[ROUND_COUNT-1]}
                     : {a_q[ROUND_COUNT-1], b_q[ROUND_COUNT-1]};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##32 done_o)
    else $error("result strobe missing 32 cycles after start");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[ROUND_COUNT-2]))
    else $error("result strobe without an item in the pipeline");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> busy)
    else $error("key write did not start expansion");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_busy_q |-> (exp_cnt_q <= LastStep))
    else $error("key expansion counter overran");

endmodule
